FILE: hw/rtl/best_pair_cosine_match_macros.svh
// Assertion macros shared by the search block.
`ifndef BEST_PAIR_COSINE_MATCH_MACROS_SVH
`define BEST_PAIR_COSINE_MATCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPCM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/bpcm_pkg.sv
`timescale 1ns / 1ps

package bpcm_pkg;

    // Storage limits.
    localparam int MAX_DIM  = 64;
    localparam int MAX_DOCS = 64;

    // Derived widths.
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int DOC_W   = $clog2(MAX_DOCS);
    localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DOCS);
    localparam int CPTR_W  = ADDR_W + 1;
    localparam int LEN_W   = 7;
    localparam int IDX_W   = 6;
    localparam int ELEM_W  = 16;
    localparam int SUM_W   = ELEM_W + 1;
    localparam int ACC_W   = 2 * SUM_W + DIM_W;
    localparam int ROOT_W  = ACC_W / 2;
    localparam int QUO_W   = 17;
    localparam int DIV_W   = ACC_W + QUO_W - 1;
    localparam int CNT_W   = 5;
    localparam int CFG_IDX_W = 2;

    // Actions.
    localparam logic [1:0] ACT_LOAD_QUERY   = 2'd0;
    localparam logic [1:0] ACT_LOAD_CONTEXT = 2'd1;
    localparam logic [1:0] ACT_RUN          = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOC_COUNT     = 2'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load_query;
        logic             load_context;
        logic             rewind;
        logic             issue;
        logic             pair;
        logic [DOC_W-1:0] doc_i;
        logic [DOC_W-1:0] doc_j;
        logic [DIM_W-1:0] elem_k;
        logic             sqrt_init;
        logic             sqrt_step;
        logic             mul;
        logic             div_init;
        logic             div_step;
        logic             score;
        logic             best_update;
        logic             first_doc;
        logic             out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [DIM_W-1:0] vl_m1;
        logic [DOC_W-1:0] dc_m1;
        logic             out_busy;
    } sts_t;

endpackage

FILE: hw/rtl/bpcm_ifs.sv
`timescale 1ns / 1ps

// Input request channel.
interface bpcm_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic signed [15:0] element_value;
    modport source (output valid, output action, output element_value, input ready);
    modport sink (input valid, input action, input element_value, output ready);
endinterface

// Result request channel.
interface bpcm_result_if;
    logic        valid;
    logic        ready;
    logic [5:0]  best_index;
    logic [5:0]  partner_index;
    logic        partner_valid;
    logic signed [15:0] best_score;
    modport source (output valid, output best_index, output partner_index,
                    output partner_valid, output best_score, input ready);
    modport sink (input valid, input best_index, input partner_index,
                  input partner_valid, input best_score, output ready);
endinterface

// Configuration write channel.
interface bpcm_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/bpcm_dp.sv
`timescale 1ns / 1ps

module bpcm_dp
    import bpcm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic [ELEM_W-1:0]        elem,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [LEN_W-1:0]         cfg_data,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [IDX_W-1:0]         out_best_index,
    output logic [IDX_W-1:0]         out_partner_index,
    output logic                     out_partner_valid,
    output logic signed [ELEM_W-1:0] out_best_score
);

    logic [LEN_W-1:0]  vl_reg, dc_reg, vl_eff, dc_eff;
    logic [LEN_W-1:0]  qptr_reg;
    logic [CPTR_W-1:0] cptr_reg;
    logic [2*LEN_W-1:0] ctx_limit;
    logic              q_we, c_we;

    logic [ELEM_W-1:0] qmem [MAX_DIM];
    logic [ELEM_W-1:0] cmem [MAX_DIM*MAX_DOCS];
    logic [ELEM_W-1:0] q_rd_reg, ca_rd_reg, cb_rd_reg;
    logic [CPTR_W-1:0] addr_a, addr_b;

    logic              v1_reg, v2_reg, pair1_reg;
    logic signed [SUM_W-1:0]   q_ext, c_sum;
    logic signed [2*SUM_W-1:0] dot_p_reg, qq_p_reg, cc_p_reg;
    logic signed [ACC_W-1:0]   acc_dot_reg;
    logic [ACC_W-1:0]          acc_qq_reg, acc_cc_reg;

    logic              neg_reg, zero_reg;
    logic [ACC_W-1:0]  mag_reg;
    logic [ACC_W-1:0]  sv_q_reg, sr_q_reg, sv_c_reg, sr_c_reg, bit_reg;
    logic [ACC_W-1:0]  sv_q_next, sr_q_next, sv_c_next, sr_c_next;
    logic [ACC_W-1:0]  den_reg;
    logic [DIV_W-1:0]  rem_reg, dsh_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic signed [ELEM_W-1:0] score;

    logic signed [ELEM_W-1:0] cur_score_reg, best_score_reg;
    logic [DOC_W-1:0]  cur_partner_reg, best_partner_reg, best_index_reg;
    logic              cur_pvalid_reg, best_pvalid_reg;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_bi_reg, out_pi_reg;
    logic              out_pv_reg;
    logic signed [ELEM_W-1:0] out_bs_reg;

    // Effective register values are saturated into the legal range.
    always_comb
    begin
        vl_eff = vl_reg;
        if (vl_reg == '0) vl_eff = LEN_W'(1);
        else if (vl_reg > LEN_W'(MAX_DIM)) vl_eff = LEN_W'(MAX_DIM);
        dc_eff = dc_reg;
        if (dc_reg == '0) dc_eff = LEN_W'(1);
        else if (dc_reg > LEN_W'(MAX_DOCS)) dc_eff = LEN_W'(MAX_DOCS);
    end

    assign ctx_limit = (2*LEN_W)'(vl_eff) * (2*LEN_W)'(dc_eff);
    assign q_we = cmd.load_query && (qptr_reg < vl_eff);
    assign c_we = cmd.load_context && ((2*LEN_W)'(cptr_reg) < ctx_limit);

    assign sts.vl_m1    = DIM_W'(vl_eff - LEN_W'(1));
    assign sts.dc_m1    = DOC_W'(dc_eff - LEN_W'(1));
    assign sts.out_busy = out_valid_reg && !out_ready;

    // Configuration registers and load pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vl_reg   <= LEN_W'(64);
            dc_reg   <= LEN_W'(64);
            qptr_reg <= '0;
            cptr_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_VECTOR_LENGTH) vl_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_DOC_COUNT) dc_reg <= cfg_data;
            if (cmd.rewind)
            begin
                qptr_reg <= '0;
                cptr_reg <= '0;
            end
            else
            begin
                if (q_we) qptr_reg <= qptr_reg + LEN_W'(1);
                if (c_we) cptr_reg <= cptr_reg + CPTR_W'(1);
            end
        end
    end

    // Vector stores with registered reads; the context store has two read ports.
    assign addr_a = CPTR_W'(cmd.doc_i) * CPTR_W'(vl_eff) + CPTR_W'(cmd.elem_k);
    assign addr_b = CPTR_W'(cmd.doc_j) * CPTR_W'(vl_eff) + CPTR_W'(cmd.elem_k);

    always_ff @(posedge clk)
    begin
        if (q_we) qmem[qptr_reg[DIM_W-1:0]] <= elem;
        q_rd_reg <= qmem[cmd.elem_k];
    end

    always_ff @(posedge clk)
    begin
        if (c_we) cmem[cptr_reg[ADDR_W-1:0]] <= elem;
        ca_rd_reg <= cmem[addr_a[ADDR_W-1:0]];
        cb_rd_reg <= cmem[addr_b[ADDR_W-1:0]];
    end

    // Element sum and the three products.
    assign q_ext = SUM_W'($signed(q_rd_reg));
    assign c_sum = SUM_W'($signed(ca_rd_reg))
                 + (pair1_reg ? SUM_W'($signed(cb_rd_reg)) : SUM_W'(0));

    always_ff @(posedge clk)
    begin
        dot_p_reg <= q_ext * c_sum;
        qq_p_reg  <= q_ext * q_ext;
        cc_p_reg  <= c_sum * c_sum;
    end

    // Square-root steps for both magnitudes, one result bit per cycle.
    always_comb
    begin
        sv_q_next = sv_q_reg;
        sr_q_next = sr_q_reg >> 1;
        if (sv_q_reg >= sr_q_reg + bit_reg)
        begin
            sv_q_next = sv_q_reg - (sr_q_reg + bit_reg);
            sr_q_next = (sr_q_reg >> 1) + bit_reg;
        end
        sv_c_next = sv_c_reg;
        sr_c_next = sr_c_reg >> 1;
        if (sv_c_reg >= sr_c_reg + bit_reg)
        begin
            sv_c_next = sv_c_reg - (sr_c_reg + bit_reg);
            sr_c_next = (sr_c_reg >> 1) + bit_reg;
        end
    end

    // Quotient saturated into a Q1.15 score.
    always_comb
    begin
        if (zero_reg)
            score = '0;
        else if (!neg_reg)
            score = (quo_reg > QUO_W'(32767)) ? 16'sh7FFF : $signed(quo_reg[ELEM_W-1:0]);
        else if (quo_reg >= QUO_W'(32768))
            score = 16'sh8000;
        else
            score = $signed(ELEM_W'(~quo_reg[ELEM_W-1:0] + ELEM_W'(1)));
    end

    // Capture the sums, take roots, multiply and divide.
    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_init)
        begin
            neg_reg  <= acc_dot_reg < 0;
            mag_reg  <= (acc_dot_reg < 0) ? ACC_W'(-acc_dot_reg) : ACC_W'(acc_dot_reg);
            zero_reg <= (acc_qq_reg == '0) || (acc_cc_reg == '0);
            sv_q_reg <= acc_qq_reg;
            sv_c_reg <= acc_cc_reg;
            sr_q_reg <= '0;
            sr_c_reg <= '0;
            bit_reg  <= ACC_W'(1) << (ACC_W - 2);
        end
        else if (cmd.sqrt_step)
        begin
            sv_q_reg <= sv_q_next;
            sr_q_reg <= sr_q_next;
            sv_c_reg <= sv_c_next;
            sr_c_reg <= sr_c_next;
            bit_reg  <= bit_reg >> 2;
        end
        if (cmd.mul)
        begin
            den_reg <= ACC_W'(sr_q_reg[ROOT_W-1:0]) * ACC_W'(sr_c_reg[ROOT_W-1:0]);
            rem_reg <= DIV_W'(mag_reg) << 15;
        end
        else if (cmd.div_init)
        begin
            dsh_reg <= DIV_W'(den_reg) << (QUO_W - 1);
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Pipeline valids and the sums of products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            pair1_reg   <= 1'b0;
            acc_dot_reg <= '0;
            acc_qq_reg  <= '0;
            acc_cc_reg  <= '0;
        end
        else
        begin
            v1_reg    <= cmd.issue;
            v2_reg    <= v1_reg;
            pair1_reg <= cmd.pair;
            if (cmd.sqrt_init)
            begin
                acc_dot_reg <= '0;
                acc_qq_reg  <= '0;
                acc_cc_reg  <= '0;
            end
            else if (v2_reg)
            begin
                acc_dot_reg <= acc_dot_reg + ACC_W'(dot_p_reg);
                acc_qq_reg  <= acc_qq_reg + ACC_W'(qq_p_reg);
                acc_cc_reg  <= acc_cc_reg + ACC_W'(cc_p_reg);
            end
        end
    end

    // Running score per document, the best over all documents, and the output register.
    always_ff @(posedge clk)
    begin
        if (cmd.score)
        begin
            if (!cmd.pair)
            begin
                cur_score_reg   <= score;
                cur_partner_reg <= '0;
                cur_pvalid_reg  <= 1'b0;
            end
            else if (score > cur_score_reg)
            begin
                cur_score_reg   <= score;
                cur_partner_reg <= cmd.doc_j;
                cur_pvalid_reg  <= 1'b1;
            end
        end
        if (cmd.best_update && (cmd.first_doc || cur_score_reg > best_score_reg))
        begin
            best_score_reg   <= cur_score_reg;
            best_index_reg   <= cmd.doc_i;
            best_partner_reg <= cur_partner_reg;
            best_pvalid_reg  <= cur_pvalid_reg;
        end
        if (cmd.out_load)
        begin
            out_bi_reg <= IDX_W'(best_index_reg);
            out_pi_reg <= IDX_W'(best_partner_reg);
            out_pv_reg <= best_pvalid_reg;
            out_bs_reg <= best_score_reg;
        end
    end

    // Output register valid.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) out_valid_next = 1'b1;
        else if (out_ready) out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else        out_valid_reg <= out_valid_next;
    end

    assign out_valid         = out_valid_reg;
    assign out_best_index    = out_bi_reg;
    assign out_partner_index = out_pi_reg;
    assign out_partner_valid = out_pv_reg;
    assign out_best_score    = out_bs_reg;

endmodule

FILE: hw/rtl/bpcm_ctrl.sv
`timescale 1ns / 1ps
`include "best_pair_cosine_match_macros.svh"

module bpcm_ctrl
    import bpcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_action,
    input  sts_t       sts,
    output cmd_t       cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_ACC    = 9'b000000010,
        S_DRAIN  = 9'b000000100,
        S_SQRT   = 9'b000001000,
        S_MUL    = 9'b000010000,
        S_DIV    = 9'b000100000,
        S_SCORE  = 9'b001000000,
        S_NEXT   = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    localparam logic [CNT_W-1:0] DRAIN_LAST = CNT_W'(2);
    localparam logic [CNT_W-1:0] SQRT_LAST  = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(QUO_W);

    state_t           state_reg, state_next;
    logic [DIM_W-1:0] k_reg, k_next;
    logic [DOC_W-1:0] i_reg, i_next, j_reg, j_next;
    logic             pair_reg, pair_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept, more_pairs;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign more_pairs = pair_reg ? (DOC_W'(j_reg + DOC_W'(1)) != i_reg) : (i_reg != '0);

    // Sequencing over documents, pairs and elements.
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pair_next  = pair_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.pair   = pair_reg;
        cmd.doc_i  = i_reg;
        cmd.doc_j  = j_reg;
        cmd.elem_k = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_action == ACT_LOAD_QUERY) cmd.load_query = 1'b1;
                if (accept && in_action == ACT_LOAD_CONTEXT) cmd.load_context = 1'b1;
                if (accept && in_action == ACT_RUN)
                begin
                    cmd.rewind = 1'b1;
                    k_next     = '0;
                    i_next     = '0;
                    j_next     = '0;
                    pair_next  = 1'b0;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.issue = 1'b1;
                if (k_reg == sts.vl_m1)
                begin
                    k_next     = '0;
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    k_next = k_reg + DIM_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (cnt_reg == DRAIN_LAST)
                begin
                    cmd.sqrt_init = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == '0) cmd.div_init = 1'b1;
                else cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST) state_next = S_SCORE;
                else cnt_next = cnt_reg + CNT_W'(1);
            end
            S_SCORE:
            begin
                cmd.score = 1'b1;
                if (more_pairs)
                begin
                    j_next     = pair_reg ? DOC_W'(j_reg + DOC_W'(1)) : '0;
                    pair_next  = 1'b1;
                    state_next = S_ACC;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                cmd.best_update = 1'b1;
                cmd.first_doc   = (i_reg == '0);
                if (i_reg == sts.dc_m1)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    i_next     = i_reg + DOC_W'(1);
                    j_next     = '0;
                    pair_next  = 1'b0;
                    state_next = S_ACC;
                end
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            pair_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            pair_reg  <= pair_next;
            cnt_reg   <= cnt_next;
        end
    end

    // A run request starts the element walk on the next cycle.
    `BPCM_ASSERT_NEXT(a_run_starts, clk, rst_n, accept && in_action == ACT_RUN, state_reg == S_ACC, "run did not start")
    // The element index stays within the vector length.
    `BPCM_ASSERT_NOW(a_k_range, clk, rst_n, state_reg == S_ACC, k_reg <= sts.vl_m1, "element index out of range")
    // A pair partner always precedes the current document.
    `BPCM_ASSERT_NOW(a_pair_order, clk, rst_n, pair_reg, j_reg < i_reg, "pair partner not earlier")
    // A result is loaded only into a free output register.
    `BPCM_ASSERT_NOW(a_out_free, clk, rst_n, cmd.out_load, !sts.out_busy, "result overwrote pending output")

endmodule

FILE: hw/rtl/best_pair_cosine_match.sv
`timescale 1ns / 1ps

// Cosine-similarity search with pair scoring. Load requests (query or context
// element) are taken one per cycle while the block is idle. A run request walks
// every document and every earlier-partner pair; each score streams the elements
// through the context memory's two read ports and the product stage, then takes
// the square root of both magnitudes, multiplies the roots and divides, and then
// updates the running score; each document's score is then held to the best one.
// The block takes no request during a run; the
// result waits in an output register while new loads are accepted.
module best_pair_cosine_match
    import bpcm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    bpcm_item_if.sink     item,
    bpcm_result_if.source result,
    bpcm_cfg_if.sink      cfg
);

    cmd_t cmd;
    sts_t sts;

    assign cfg.ready = 1'b1;

    // Sequencer.
    bpcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .in_action (item.action),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Stores, arithmetic and result register.
    bpcm_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .elem              (item.element_value),
        .cfg_we            (cfg.valid),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .out_ready         (result.ready),
        .out_valid         (result.valid),
        .out_best_index    (result.best_index),
        .out_partner_index (result.partner_index),
        .out_partner_valid (result.partner_valid),
        .out_best_score    (result.best_score)
    );

endmodule

FILE: test/bpcm_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and configuration channels of the search block.
// It keeps its own copy of the stores and registers, predicts the outcome of
// every run request and compares each result request with the oldest
// prediction.
module bpcm_checker
    import bpcm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    bpcm_item_if   item,
    bpcm_result_if result,
    bpcm_cfg_if    cfg,
    output int     fail_count,
    output int     pending
);

    typedef struct packed {
        logic [IDX_W-1:0]         best;
        logic [IDX_W-1:0]         partner;
        logic                     paired;
        logic signed [ELEM_W-1:0] score;
    } match_t;

    logic [LEN_W-1:0]         len_reg;
    logic [LEN_W-1:0]         docs_reg;
    logic signed [ELEM_W-1:0] query_mem [MAX_DIM];
    logic signed [ELEM_W-1:0] context_mem [MAX_DIM * MAX_DOCS];
    int                       query_fill;
    int                       context_fill;
    int                       errors;
    match_t                   match_queue [$];

    // A register value saturated into 1..limit.
    function automatic int clamp_count(logic [LEN_W-1:0] raw, int limit);
        if (raw == 0)
            return 1;
        if (raw > limit)
            return limit;
        return int'(raw);
    endfunction

    // Floor square root; every magnitude here stays below 2^42.
    function automatic longint floor_root(longint v);
        longint r;
        longint t;
        r = 0;
        for (int b = 22; b >= 0; b--)
        begin
            t = r | (longint'(1) << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // Cosine of the query with document i, or with documents i and j summed.
    function automatic int cosine(int i, int j, bit paired, int vl);
        longint dot;
        longint qq;
        longint cc;
        longint q;
        longint c;
        longint mag;
        longint quo;
        dot = 0;
        qq = 0;
        cc = 0;
        for (int k = 0; k < vl; k++)
        begin
            q = query_mem[k];
            c = context_mem[i * vl + k];
            if (paired)
                c += context_mem[j * vl + k];
            dot += q * c;
            qq += q * q;
            cc += c * c;
        end
        if (qq == 0 || cc == 0)
            return 0;
        mag = (dot < 0) ? -dot : dot;
        quo = (mag << 15) / (floor_root(qq) * floor_root(cc));
        if (dot >= 0)
            return (quo > 32767) ? 32767 : int'(quo);
        return (quo > 32768) ? -32768 : -int'(quo);
    endfunction

    // Scores every document and pair, then picks the earliest best one.
    function automatic match_t best_match();
        int     vl;
        int     dc;
        int     s;
        int     best;
        int     score [MAX_DOCS];
        int     partner [MAX_DOCS];
        match_t m;
        vl = clamp_count(len_reg, MAX_DIM);
        dc = clamp_count(docs_reg, MAX_DOCS);
        for (int i = 0; i < dc; i++)
        begin
            score[i] = cosine(i, 0, 1'b0, vl);
            partner[i] = -1;
        end
        for (int i = 0; i < dc; i++)
        begin
            for (int j = 0; j < i; j++)
            begin
                s = cosine(i, j, 1'b1, vl);
                if (s > score[i])
                begin
                    score[i] = s;
                    partner[i] = j;
                end
            end
        end
        best = 0;
        for (int i = 1; i < dc; i++)
        begin
            if (score[i] > score[best])
                best = i;
        end
        m.best = best[IDX_W-1:0];
        m.paired = (partner[best] >= 0);
        m.partner = m.paired ? partner[best][IDX_W-1:0] : '0;
        m.score = score[best][ELEM_W-1:0];
        return m;
    endfunction

    // Prints one field that differs from its prediction.
    task automatic report(string field, int want, int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
    endtask

    // Track every accepted request on the three channels.
    always @(posedge clk or negedge rst_n)
    begin
        match_t want;
        int     vl;
        int     dc;
        if (!rst_n)
        begin
            len_reg = 7'd64;
            docs_reg = 7'd64;
            query_fill = 0;
            context_fill = 0;
            errors = 0;
            match_queue.delete();
        end
        else
        begin
            // Configuration writes.
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_VECTOR_LENGTH)
                    len_reg = cfg.data;
                else if (cfg.index == CFG_DOC_COUNT)
                    docs_reg = cfg.data;
            end

            // Results are compared with the oldest prediction.
            if (result.valid && result.ready)
            begin
                if (match_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, best %0d score %0d", $time,
                             result.best_index, result.best_score);
                    errors++;
                end
                else
                begin
                    want = match_queue.pop_front();
                    if (result.best_index !== want.best)
                        report("best_index", want.best, result.best_index);
                    if (result.partner_index !== want.partner)
                        report("partner_index", want.partner, result.partner_index);
                    if (result.partner_valid !== want.paired)
                        report("partner_valid", want.paired, result.partner_valid);
                    if (result.best_score !== want.score)
                        report("best_score", want.score, result.best_score);
                end
            end

            // Load and run requests.
            if (item.valid && item.ready)
            begin
                vl = clamp_count(len_reg, MAX_DIM);
                dc = clamp_count(docs_reg, MAX_DOCS);
                if (item.action == ACT_LOAD_QUERY)
                begin
                    if (query_fill < vl)
                    begin
                        query_mem[query_fill] = item.element_value;
                        query_fill++;
                    end
                end
                else if (item.action == ACT_LOAD_CONTEXT)
                begin
                    if (context_fill < vl * dc)
                    begin
                        context_mem[context_fill] = item.element_value;
                        context_fill++;
                    end
                end
                else if (item.action == ACT_RUN)
                begin
                    query_fill = 0;
                    context_fill = 0;
                    match_queue.push_back(best_match());
                end
            end
        end
        pending <= match_queue.size();
        fail_count <= errors;
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

// Drives load, run and configuration requests into the search block and
// gives the verdict from the checker's failure count.
module tb_top;
    import bpcm_pkg::*;

    localparam longint CYCLE_LIMIT = 8000000;
    localparam int      ITEM_GOAL   = 2000;
    localparam int      PHASE_ITEMS = 300;

    // Codes the block has to ignore.
    localparam logic [1:0]           ACT_IGNORED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic   clk;
    logic   rst_n;
    int     fail_count;
    int     pending;
    longint cycles;
    int     send_idle;
    int     recv_stall;
    logic   hold_start;
    int     hold_left;

    // Stimulus-side view of the stores, so a run never reads an unwritten element.
    int                       cur_len;
    int                       cur_docs;
    int                       query_fill;
    int                       context_fill;
    int                       item_count;
    bit                       query_seen [MAX_DIM];
    bit                       context_seen [MAX_DIM * MAX_DOCS];
    logic signed [ELEM_W-1:0] query_val [MAX_DIM];

    bpcm_item_if   item ();
    bpcm_result_if result ();
    bpcm_cfg_if    cfg ();

    best_pair_cosine_match uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    bpcm_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("best_pair_cosine_match regression: fail");
            $finish;
        end
    end

    // Result side: random stalls plus an occasional long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_start)
        begin
            result.ready <= 1'b0;
            hold_left <= 3000;
        end
        else if (hold_left > 0)
        begin
            result.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            result.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Saturates a register value the way the block does.
    function automatic int clamp_count(int raw, int limit);
        return (raw < 1) ? 1 : ((raw > limit) ? limit : raw);
    endfunction

    // An element: fully random, an extreme, or close to a query element.
    function automatic logic signed [ELEM_W-1:0] pick_elem(int k);
        int v;
        case ($urandom_range(9))
            0, 1, 2: return ELEM_W'($urandom);
            3:
            begin
                case ($urandom_range(4))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    3: return 16'sh0001;
                    default: return 16'shffff;
                endcase
            end
            default:
            begin
                v = int'(query_val[k % cur_len]) + $urandom_range(4000) - 2000;
                v = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
                return v[ELEM_W-1:0];
            end
        endcase
    endfunction

    // Sends one request and follows the load pointers.
    task automatic send_item(logic [1:0] act, logic signed [ELEM_W-1:0] v);
        while ($urandom_range(99) < send_idle)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid <= 1'b1;
        item.action <= act;
        item.element_value <= v;
        do
            @(posedge clk);
        while (!item.ready);
        item_count++;
        if (act == ACT_LOAD_QUERY && query_fill < cur_len)
        begin
            query_seen[query_fill] = 1'b1;
            query_val[query_fill] = v;
            query_fill++;
        end
        else if (act == ACT_LOAD_CONTEXT && context_fill < cur_len * cur_docs)
        begin
            context_seen[context_fill] = 1'b1;
            context_fill++;
        end
        else if (act == ACT_RUN)
        begin
            query_fill = 0;
            context_fill = 0;
        end
    endtask

    // Stops offering requests until every predicted result has come back.
    task automatic drain();
        item.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes one register while the block is idle.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int value);
        drain();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value[LEN_W-1:0];
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == CFG_VECTOR_LENGTH)
            cur_len = clamp_count(value, MAX_DIM);
        else if (idx == CFG_DOC_COUNT)
            cur_docs = clamp_count(value, MAX_DOCS);
    endtask

    task automatic set_sizes(int len, int docs);
        write_cfg(CFG_VECTOR_LENGTH, len);
        write_cfg(CFG_DOC_COUNT, docs);
    endtask

    // True when a run now would read only elements written since reset.
    function automatic bit stores_ready();
        for (int k = 0; k < cur_len; k++)
            if (!query_seen[k])
                return 1'b0;
        for (int a = 0; a < cur_len * cur_docs; a++)
            if (!context_seen[a])
                return 1'b0;
        return 1'b1;
    endfunction

    // A full query and context load with random content, then a run.
    task automatic full_search(bit noisy);
        for (int k = 0; k < cur_len; k++)
            send_item(ACT_LOAD_QUERY, ($urandom_range(9) == 0) ? pick_elem(k)
                                      : ELEM_W'($urandom));
        for (int a = 0; a < cur_len * cur_docs; a++)
            send_item(ACT_LOAD_CONTEXT, pick_elem(a));
        if (noisy)
        begin
            // Loads past the limits are dropped; the unused action is ignored.
            send_item(ACT_LOAD_QUERY, ELEM_W'($urandom));
            send_item(ACT_LOAD_CONTEXT, ELEM_W'($urandom));
            send_item(ACT_IGNORED, ELEM_W'($urandom));
        end
        send_item(ACT_RUN, ELEM_W'($urandom));
    endtask

    initial
    begin
        int len_raw;
        int docs_raw;
        int phase;
        int loop_start;
        cycles = 0;
        send_idle = 0;
        recv_stall = 0;
        hold_start = 1'b0;
        item_count = 0;
        query_fill = 0;
        context_fill = 0;
        cur_len = MAX_DIM;
        cur_docs = MAX_DOCS;
        foreach (query_val[k])
            query_val[k] = '0;
        item.valid = 1'b0;
        item.action = ACT_LOAD_QUERY;
        item.element_value = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_VECTOR_LENGTH;
        cfg.data = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unknown register indexes are ignored.
        write_cfg(CFG_SPARE_LO, 5);
        write_cfg(CFG_SPARE_HI, 9);
        set_sizes(2, 3);

        // A document equal to the query saturates high, its negation low,
        // and a zero document scores zero.
        send_item(ACT_LOAD_QUERY, 16'sh7fff);
        send_item(ACT_LOAD_QUERY, 16'sh8000);
        send_item(ACT_LOAD_QUERY, 16'sh1234);
        send_item(ACT_LOAD_CONTEXT, 16'sh7fff);
        send_item(ACT_LOAD_CONTEXT, 16'sh8000);
        send_item(ACT_LOAD_CONTEXT, 16'sh8001);
        send_item(ACT_LOAD_CONTEXT, 16'sh7fff);
        send_item(ACT_LOAD_CONTEXT, 16'sh0000);
        send_item(ACT_LOAD_CONTEXT, 16'sh0000);
        send_item(ACT_LOAD_CONTEXT, 16'sh5555);
        send_item(ACT_IGNORED, 16'sh0000);
        send_item(ACT_RUN, 16'sh0000);

        // A zero query scores zero everywhere.
        send_item(ACT_LOAD_QUERY, 16'sh0000);
        send_item(ACT_LOAD_QUERY, 16'sh0000);
        send_item(ACT_RUN, 16'shffff);

        // Orthogonal halves whose pair sum matches the query, with tied documents.
        send_item(ACT_LOAD_QUERY, 16'sh4000);
        send_item(ACT_LOAD_QUERY, 16'sh4000);
        send_item(ACT_LOAD_CONTEXT, 16'sh4000);
        send_item(ACT_LOAD_CONTEXT, 16'sh0000);
        send_item(ACT_LOAD_CONTEXT, 16'sh0000);
        send_item(ACT_LOAD_CONTEXT, 16'sh4000);
        send_item(ACT_LOAD_CONTEXT, 16'sh4000);
        send_item(ACT_LOAD_CONTEXT, 16'sh0000);
        send_item(ACT_RUN, 16'sh0000);

        // Register extremes, including values that saturate.
        set_sizes(0, 127);
        full_search(1'b0);
        set_sizes(127, 0);
        full_search(1'b1);
        set_sizes(64, 8);
        full_search(1'b0);
        set_sizes(1, 1);
        full_search(1'b1);

        // Random searches over four idling phases.
        loop_start = item_count;
        while (item_count < ITEM_GOAL)
        begin
            phase = ((item_count - loop_start) / PHASE_ITEMS) % 4;
            if (phase < 0)
                phase = 0;
            send_idle = (phase == 1) ? 64 : ((phase == 3) ? 22 : 0);
            recv_stall = (phase == 2) ? 64 : ((phase == 3) ? 22 : 0);

            if ($urandom_range(3) == 0)
            begin
                len_raw = ($urandom_range(9) < 8) ? $urandom_range(1, 8)
                          : $urandom_range(0, 127);
                docs_raw = ($urandom_range(9) < 8) ? $urandom_range(1, 6)
                           : $urandom_range(0, 16);
                set_sizes(len_raw, docs_raw);
            end

            if ($urandom_range(40) == 0)
            begin
                // The result side holds off while two runs and one more load
                // are offered, so a second result is kept back inside the block
                // and the load has to wait at the input.
                item.valid <= 1'b0;
                hold_start <= 1'b1;
                @(posedge clk);
                hold_start <= 1'b0;
                full_search(1'b0);
                full_search(1'b0);
                send_item(ACT_LOAD_QUERY, ELEM_W'($urandom));
                drain();
            end
            else if ($urandom_range(4) != 0)
            begin
                full_search($urandom_range(3) == 0);
            end
            else
            begin
                // Partial reload: the run reuses older elements where present.
                repeat ($urandom_range(cur_len))
                    send_item(ACT_LOAD_QUERY, ELEM_W'($urandom));
                repeat ($urandom_range(cur_len * cur_docs))
                    send_item(ACT_LOAD_CONTEXT, pick_elem($urandom_range(63)));
                if (stores_ready())
                    send_item(ACT_RUN, ELEM_W'($urandom));
                else
                    send_item(ACT_IGNORED, ELEM_W'($urandom));
            end

            if ($urandom_range(15) == 0)
                drain();
        end

        drain();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("best_pair_cosine_match regression: pass");
        else
            $display("best_pair_cosine_match regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/bpcm_pkg.sv
hw/rtl/bpcm_ifs.sv
hw/rtl/bpcm_dp.sv
hw/rtl/bpcm_ctrl.sv
hw/rtl/best_pair_cosine_match.sv
test/bpcm_checker.sv
test/tb_top.sv
